[sv/nsf_pkg.sv]
`timescale 1ns / 1ps
package nsf_pkg;

  // Sentence limits.
  localparam int MAX_SENTENCE_LEN = 81;
  localparam int MAX_ADDRESS_LEN  = 10;

  // Only the first five address letters can ever select a named kind.
  localparam int ADDR_KEEP   = 5;
  localparam int NUM_KINDS   = 6;
  localparam int LEN_W       = 7;
  localparam int ADDR_CNT_W  = 4;
  localparam int KIND_W      = 3;

  // Characters of interest.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // Sentence kinds.
  localparam logic [KIND_W-1:0] KIND_GGA   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GSA   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GSV   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RMB   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RMC   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ZDA   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd6;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_DATA,
    PH_HEX1,
    PH_HEX2,
    PH_END
  } phase_t;

  typedef logic [ADDR_KEEP-1:0][7:0] addr_chars_t;

  // Address names, first letter in element 0.
  localparam addr_chars_t KIND_NAMES [NUM_KINDS] = '{
    '{8'h41, 8'h47, 8'h47, 8'h50, 8'h47},
    '{8'h41, 8'h53, 8'h47, 8'h50, 8'h47},
    '{8'h56, 8'h53, 8'h47, 8'h50, 8'h47},
    '{8'h42, 8'h4D, 8'h52, 8'h50, 8'h47},
    '{8'h43, 8'h4D, 8'h52, 8'h50, 8'h47},
    '{8'h41, 8'h44, 8'h5A, 8'h50, 8'h47}
  };

  function automatic logic is_upper_hex(input logic [7:0] c);
    return (c inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_F]});
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else begin
      v = c - CH_UP_A + 8'd10;
    end
    return v[3:0];
  endfunction

  // Kind lookup: a named kind needs exactly five matching letters.
  function automatic logic [KIND_W-1:0] kind_of(input addr_chars_t chars,
                                                input logic [ADDR_CNT_W-1:0] cnt);
    logic [KIND_W-1:0] k;
    k = KIND_OTHER;
    if (cnt == ADDR_CNT_W'(ADDR_KEEP)) begin
      for (int i = NUM_KINDS - 1; i >= 0; i--) begin
        if (chars == KIND_NAMES[i]) begin
          k = KIND_W'(i);
        end
      end
    end
    return k;
  endfunction

endpackage

[sv/nsf_if.sv]
`timescale 1ns / 1ps
interface nsf_rx_if import nsf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsf_res_if import nsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] sentence_kind;
  logic [LEN_W-1:0]  sentence_length;
  logic              checksum_verified;

  modport source (output valid, output sentence_kind, output sentence_length,
                  output checksum_verified, input ready);
  modport sink (input valid, input sentence_kind, input sentence_length,
                input checksum_verified, output ready);
endinterface

[sv/nmea_sentence_framer_core.sv]
`timescale 1ns / 1ps
// NMEA 0183 sentence framer.
// The rx channel carries one received character per word. The framer hunts
// for a dollar sign, collects the address up to the comma, keeps a running
// XOR and checks the optional two-digit checksum after the star. A carriage
// return closes a sentence and yields one word on res with the sentence kind,
// whether a checksum was checked and the length: characters after the dollar
// sign through the CR, less line feeds that follow the checksum or a line feed.
// Throughput is one character per cycle while rx is ready. A result appears on
// res in the cycle after the carriage return is accepted; all parsing is done by
// the logic between the parser state registers and the single result register.
// When the receiver stalls, the result register holds its word and rx stays
// ready only while that register is empty or being taken in the same cycle.
// A stall therefore holds back at most one sentence end.
// Synchronous reset returns the parser to hunting for a dollar sign and
// empties the result register; the stored address letters are not cleared.
module nmea_sentence_framer_core import nsf_pkg::*; (
  input logic      clk,
  input logic      rst,
  nsf_rx_if.sink   rx,
  nsf_res_if.source res
);

  phase_t                phase, phase_next;
  logic [7:0]            running_xor, running_xor_next;
  addr_chars_t           address_chars;
  logic [ADDR_CNT_W-1:0] address_count, address_count_next;
  logic [LEN_W-1:0]      char_count, char_count_next;
  logic [3:0]            high_hex_digit, high_hex_digit_next;
  logic                  had_checksum, had_checksum_next;
  logic                  addr_we;
  logic                  emit;
  logic                  accept;
  logic                  full;
  logic [7:0]            c;

  assign c      = rx.rx_byte;
  assign full   = (char_count >= LEN_W'(MAX_SENTENCE_LEN - 1));
  assign accept = rx.valid && rx.ready;
  assign rx.ready = !res.valid || res.ready;

  // Next-state logic of the parser.
  always_comb begin
    phase_next          = phase;
    running_xor_next    = running_xor;
    address_count_next  = address_count;
    char_count_next     = char_count;
    high_hex_digit_next = high_hex_digit;
    had_checksum_next   = had_checksum;
    addr_we             = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (c == CH_DOLLAR) begin
          address_count_next = '0;
          char_count_next    = '0;
          running_xor_next   = '0;
          had_checksum_next  = 1'b0;
          phase_next         = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (full) begin
          phase_next = PH_HUNT;
        end else begin
          char_count_next  = char_count + 1'b1;
          running_xor_next = running_xor ^ c;
          if (c == CH_COMMA) begin
            phase_next = PH_DATA;
          end else if (address_count >= ADDR_CNT_W'(MAX_ADDRESS_LEN - 1) ||
                       !(c inside {[CH_UP_A:CH_UP_Z]})) begin
            phase_next = PH_HUNT;
          end else begin
            addr_we            = (address_count < ADDR_CNT_W'(ADDR_KEEP));
            address_count_next = address_count + 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (full) begin
          phase_next = PH_HUNT;
        end else begin
          char_count_next = char_count + 1'b1;
          if (c == CH_STAR) begin
            phase_next = PH_HEX1;
          end else if (c == CH_LF) begin
            phase_next = PH_END;
          end else if (c == CH_CR) begin
            phase_next = PH_HUNT;
          end else begin
            running_xor_next = running_xor ^ c;
          end
        end
      end
      PH_HEX1: begin
        if (full || !is_upper_hex(c)) begin
          phase_next = PH_HUNT;
        end else begin
          char_count_next     = char_count + 1'b1;
          high_hex_digit_next = hex_value(c);
          phase_next          = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (full || !is_upper_hex(c)) begin
          phase_next = PH_HUNT;
        end else begin
          char_count_next = char_count + 1'b1;
          if ({high_hex_digit, hex_value(c)} == running_xor) begin
            had_checksum_next = 1'b1;
            phase_next        = PH_END;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_END: begin
        if (full || (c != CH_LF && c != CH_CR)) begin
          phase_next = PH_HUNT;
        end else if (c == CH_CR) begin
          char_count_next = char_count + 1'b1;
          phase_next      = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // A sentence ends on a CR in the data part or after a checksum or line feed.
  always_comb begin
    case (phase)
      PH_DATA, PH_END: emit = !full && (c == CH_CR);
      default:         emit = 1'b0;
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      running_xor    <= '0;
      address_count  <= '0;
      char_count     <= '0;
      high_hex_digit <= '0;
      had_checksum   <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      running_xor    <= running_xor_next;
      address_count  <= address_count_next;
      char_count     <= char_count_next;
      high_hex_digit <= high_hex_digit_next;
      had_checksum   <= had_checksum_next;
    end
  end

  // Address letters kept for the kind lookup.
  always_ff @(posedge clk) begin
    if (accept && addr_we) begin
      address_chars[address_count[$clog2(ADDR_KEEP)-1:0]] <= c;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept && emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res.sentence_kind     <= kind_of(address_chars, address_count);
      res.sentence_length   <= char_count + 1'b1;
      res.checksum_verified <= had_checksum;
    end
  end

  // The length counter never passes the sentence limit.
  assert property (@(posedge clk) disable iff (rst)
    char_count <= LEN_W'(MAX_SENTENCE_LEN - 1))
    else $error("character count beyond sentence limit");

  // A sentence end always loads a result with a nonzero length.
  assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> res.valid && res.sentence_length != '0)
    else $error("sentence end did not load a result");

  // A checked sentence holds at least a comma, star, two digits and a CR.
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.checksum_verified |-> res.sentence_length >= LEN_W'(5))
    else $error("checked sentence too short");

  // No character is taken while an untaken result waits.
  assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !rx.ready)
    else $error("input taken while result stalled");

endmodule

[tb/nmea_sentence_framer_core_test.sv]
`timescale 1ns / 1ps
module nmea_sentence_framer_core_test;
  import nsf_pkg::*;

  // One sentence word as seen on the res channel.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    logic              verified;
  } sentence_t;

  // Directed row: filler count, whether the result is typed in, and that result.
  typedef struct packed {
    logic [6:0] fill;
    logic       typed;
    logic       has_res;
    sentence_t  res;
  } dir_row_t;

  typedef enum logic [1:0] {SINK_RANDOM, SINK_STEADY, SINK_HOLD} sink_mode_t;

  localparam sentence_t  NO_SENT   = '0;
  localparam logic [7:0] FILL_MARK = "#";
  localparam logic [7:0] LOWER_A   = "a";
  localparam int         DIR_ROWS  = 25;
  localparam int         HOLD_LEN  = 400;

  localparam logic [39:0] KIND_TEXT [NUM_KINDS] = '{
    "GPGGA", "GPGSA", "GPGSV", "GPRMB", "GPRMC", "GPZDA"
  };
  localparam logic [KIND_W-1:0] KIND_CODE [NUM_KINDS] = '{
    KIND_GGA, KIND_GSA, KIND_GSV, KIND_RMB, KIND_RMC, KIND_ZDA
  };

  // A '#' in a row stands for the row's count of '0' filler characters.
  string dir_text [DIR_ROWS] = '{
    "$GPGGA,\r",
    "$GPGSA,*6E\r",
    "$GPGSV,*79\r",
    "$GPRMB,*66\r",
    "$GPRMC,A*26\n\r",
    "$GPZDA,*64\r",
    "$GPZDA,*65\r",
    "$GPGGA,*7a\r",
    "$GPGGA,*7G\r",
    "$,\r",
    "$ABCDEFGHI,\r",
    "$ABCDEFGHIJ,\r",
    "$GPGG$A,\r",
    "$GPGGAX,\r",
    "$GPXYZ,\r",
    "$gpgga,\r",
    "$GPGGA,1$2\r",
    "$GPGSA,12\n\r",
    "$GPGGA,*7A\n\n\r",
    "$GPGGA,#\r",
    "$GPGGA,#\r",
    "$GPGGA,#*7A\r",
    "$GPGGA,#*4A\r",
    "\377\200\015$GPRMC,\r",
    "$GPRMC\r$GPRMC,*\r"
  };

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{7'd0,  1'b1, 1'b1, '{KIND_GGA, 7'd7, 1'b0}},
    '{7'd0,  1'b0, 1'b0, NO_SENT},
    '{7'd0,  1'b0, 1'b0, NO_SENT},
    '{7'd0,  1'b0, 1'b0, NO_SENT},
    '{7'd0,  1'b0, 1'b0, NO_SENT},
    '{7'd0,  1'b0, 1'b0, NO_SENT},
    '{7'd0,  1'b1, 1'b0, NO_SENT},
    '{7'd0,  1'b1, 1'b0, NO_SENT},
    '{7'd0,  1'b1, 1'b0, NO_SENT},
    '{7'd0,  1'b1, 1'b1, '{KIND_OTHER, 7'd2, 1'b0}},
    '{7'd0,  1'b1, 1'b1, '{KIND_OTHER, 7'd11, 1'b0}},
    '{7'd0,  1'b1, 1'b0, NO_SENT},
    '{7'd0,  1'b1, 1'b0, NO_SENT},
    '{7'd0,  1'b1, 1'b1, '{KIND_OTHER, 7'd8, 1'b0}},
    '{7'd0,  1'b1, 1'b1, '{KIND_OTHER, 7'd7, 1'b0}},
    '{7'd0,  1'b1, 1'b0, NO_SENT},
    '{7'd0,  1'b0, 1'b0, NO_SENT},
    '{7'd0,  1'b0, 1'b0, NO_SENT},
    '{7'd0,  1'b0, 1'b0, NO_SENT},
    '{7'd73, 1'b1, 1'b1, '{KIND_GGA, 7'd80, 1'b0}},
    '{7'd74, 1'b1, 1'b0, NO_SENT},
    '{7'd70, 1'b1, 1'b1, '{KIND_GGA, 7'd80, 1'b1}},
    '{7'd71, 1'b1, 1'b0, NO_SENT},
    '{7'd0,  1'b1, 1'b1, '{KIND_RMC, 7'd7, 1'b0}},
    '{7'd0,  1'b1, 1'b0, NO_SENT}
  };

  logic clk = 1'b0;
  logic rst;

  nsf_rx_if  rx_ch ();
  nsf_res_if res_ch ();

  nmea_sentence_framer_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always #2 clk = ~clk;

  // Framer state as the checker tracks it.
  phase_t          fr_phase   = PH_HUNT;
  logic [7:0]      fr_xor     = '0;
  logic [7:0]      fr_addr [MAX_ADDRESS_LEN-1];
  logic [ADDR_CNT_W-1:0] fr_addr_n = '0;
  logic [LEN_W-1:0] fr_count  = '0;
  logic [3:0]      fr_high    = '0;
  logic            fr_checked = 1'b0;

  sentence_t  expected_sentences [$];
  sink_mode_t sink_mode = SINK_RANDOM;
  bit         src_steady = 1'b0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  int error_count = 0;
  int chars_sent = 0;
  int framed_chars = 0;
  int sentences_predicted = 0;
  int sentences_checked = 0;
  int sums_checked = 0;

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 4'(c - CH_ZERO);
      return 1'b1;
    end
    if (c >= CH_UP_A && c <= CH_UP_F) begin
      v = 4'(c - CH_UP_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_UP_A + 8'(v) - 8'd10;
  endfunction

  // A named kind needs exactly five address letters spelling its name.
  function automatic logic [KIND_W-1:0] addr_kind();
    logic [39:0] word;
    if (fr_addr_n != ADDR_CNT_W'(ADDR_KEEP)) return KIND_OTHER;
    word = {fr_addr[0], fr_addr[1], fr_addr[2], fr_addr[3], fr_addr[4]};
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (word == KIND_TEXT[k]) return KIND_CODE[k];
    end
    return KIND_OTHER;
  endfunction

  // Advances the framer by one character; returns 1 when a sentence closes.
  function automatic bit frame_step(input logic [7:0] c, output sentence_t s);
    logic       full;
    logic       done;
    logic [3:0] nib;
    full = (fr_count >= LEN_W'(MAX_SENTENCE_LEN - 1));
    done = 1'b0;
    s = NO_SENT;
    case (fr_phase)
      PH_HUNT: begin
        if (c == CH_DOLLAR) begin
          fr_addr_n = '0;
          fr_count = '0;
          fr_xor = '0;
          fr_checked = 1'b0;
          fr_phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (full) begin
          fr_phase = PH_HUNT;
        end else begin
          fr_count = fr_count + 1'b1;
          fr_xor = fr_xor ^ c;
          if (c == CH_COMMA) begin
            fr_phase = PH_DATA;
          end else if (fr_addr_n >= ADDR_CNT_W'(MAX_ADDRESS_LEN - 1) ||
                       c < CH_UP_A || c > CH_UP_Z) begin
            fr_phase = PH_HUNT;
          end else begin
            fr_addr[fr_addr_n] = c;
            fr_addr_n = fr_addr_n + 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (full) begin
          fr_phase = PH_HUNT;
        end else begin
          fr_count = fr_count + 1'b1;
          if (c == CH_STAR) fr_phase = PH_HEX1;
          else if (c == CH_LF) fr_phase = PH_END;
          else if (c == CH_CR) done = 1'b1;
          else fr_xor = fr_xor ^ c;
        end
      end
      PH_HEX1: begin
        if (full || !hex_nibble(c, nib)) begin
          fr_phase = PH_HUNT;
        end else begin
          fr_count = fr_count + 1'b1;
          fr_high = nib;
          fr_phase = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (full || !hex_nibble(c, nib)) begin
          fr_phase = PH_HUNT;
        end else begin
          fr_count = fr_count + 1'b1;
          if ({fr_high, nib} == fr_xor) begin
            fr_checked = 1'b1;
            fr_phase = PH_END;
          end else begin
            fr_phase = PH_HUNT;
          end
        end
      end
      PH_END: begin
        if (full || (c != CH_LF && c != CH_CR)) begin
          fr_phase = PH_HUNT;
        end else if (c == CH_CR) begin
          fr_count = fr_count + 1'b1;
          done = 1'b1;
        end
      end
      default: begin
        fr_phase = PH_HUNT;
      end
    endcase
    if (done) begin
      s.kind = addr_kind();
      s.len = fr_count;
      s.verified = fr_checked;
      fr_phase = PH_HUNT;
    end
    return done;
  endfunction

  // Random sentence: mostly well formed, with bad addresses, bad or missing
  // checksums, overruns, cut-off endings and line noise mixed in.
  function automatic void make_sentence(ref logic [7:0] q[$]);
    logic [7:0] body [$];
    logic [7:0] sum;
    logic [7:0] c;
    int pick;
    int n;
    q = {};
    if ($urandom_range(99) < 20) begin
      n = $urandom_range(1, 4);
      repeat (n) q.push_back(8'($urandom));
    end
    pick = $urandom_range(99);
    if (pick < 60) begin
      n = $urandom_range(0, NUM_KINDS - 1);
      for (int i = 0; i < ADDR_KEEP; i++) body.push_back(KIND_TEXT[n][39 - 8 * i -: 8]);
    end else if (pick < 85) begin
      n = $urandom_range(0, MAX_ADDRESS_LEN);
      repeat (n) body.push_back(CH_UP_A + 8'($urandom_range(0, 25)));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) body.push_back(8'($urandom));
    end
    body.push_back(CH_COMMA);
    n = ($urandom_range(99) < 8) ? $urandom_range(60, 76) : $urandom_range(0, 30);
    repeat (n) begin
      if ($urandom_range(99) < 3) begin
        c = 8'($urandom);
      end else begin
        c = 8'($urandom_range(32, 126));
        if (c == CH_STAR) c = CH_COMMA;
      end
      body.push_back(c);
    end
    sum = '0;
    foreach (body[i]) sum = sum ^ body[i];
    q.push_back(CH_DOLLAR);
    q = {q, body};
    pick = $urandom_range(99);
    if (pick < 70) begin
      if (pick >= 55 && pick < 65) sum = sum ^ 8'($urandom_range(1, 255));
      q.push_back(CH_STAR);
      q.push_back(hex_char(sum[7:4]));
      q.push_back(hex_char(sum[3:0]));
      if (pick >= 65) begin
        if ($urandom_range(1) == 0) q[$] = LOWER_A + 8'($urandom_range(0, 5));
        else q[$] = CH_UP_F + 8'($urandom_range(1, 20));
      end
      if (pick < 55 && $urandom_range(99) < 30) q.push_back(CH_LF);
      q.push_back(CH_CR);
    end else if (pick < 85) begin
      q.push_back(CH_CR);
    end else if (pick < 92) begin
      q.push_back(CH_LF);
      q.push_back(CH_CR);
    end
  endfunction

  // Offers one character word, idling first at random, and steps the tracker
  // once the word is taken.
  task automatic send_char(input logic [7:0] c, input bit push_model);
    sentence_t s;
    while (!src_steady && $urandom_range(99) < 27) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= c;
    do @(posedge clk); while (!rx_ch.ready);
    chars_sent++;
    if (fr_phase != PH_HUNT || c == CH_DOLLAR) framed_chars++;
    if (frame_step(c, s) && push_model) begin
      expected_sentences.push_back(s);
      sentences_predicted++;
    end
  endtask

  task automatic send_frame(input logic [7:0] q[$], input bit push_model);
    foreach (q[i]) send_char(q[i], push_model);
  endtask

  // Holds the sender off until every expected sentence word has arrived.
  task automatic drain();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_sentences.size() != 0);
  endtask

  // Receiver: random stalls, a steady stretch, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else if (sink_mode == SINK_HOLD && !hold_done) begin
      res_ch.ready <= 1'b0;
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end else if (sink_mode == SINK_STEADY) begin
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= 27);
    end
  end

  // Compare each accepted sentence word with the oldest expected one.
  always @(posedge clk) begin : check_results
    sentence_t got;
    sentence_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.kind = res_ch.sentence_kind;
      got.len = res_ch.sentence_length;
      got.verified = res_ch.checksum_verified;
      if (expected_sentences.size() == 0) begin
        log_error($sformatf("unexpected word: kind %0d length %0d checksum %0b",
                            got.kind, got.len, got.verified));
      end else begin
        want = expected_sentences.pop_front();
        sentences_checked++;
        if (want.verified) sums_checked++;
        if (got.kind !== want.kind) begin
          log_error($sformatf("sentence_kind expected %0d got %0d", want.kind, got.kind));
        end
        if (got.len !== want.len) begin
          log_error($sformatf("sentence_length expected %0d got %0d", want.len, got.len));
        end
        if (got.verified !== want.verified) begin
          log_error($sformatf("checksum_verified expected %0b got %0b",
                              want.verified, got.verified));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d sentences still expected.", expected_sentences.size());
    $display("nmea_sentence_framer_core verification failed");
    $finish;
  end

  initial begin
    logic [7:0] frame [$];
    string row_text;
    int rand_chars;
    int hold_base;
    int wait_cycles;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: typed rows carry their own result, the rest use the tracker.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row_text = dir_text[r];
      frame = {};
      for (int i = 0; i < row_text.len(); i++) begin
        if (row_text[i] == FILL_MARK) repeat (dir_rows[r].fill) frame.push_back(CH_ZERO);
        else frame.push_back(row_text[i]);
      end
      send_frame(frame, !dir_rows[r].typed);
      if (dir_rows[r].typed && dir_rows[r].has_res) begin
        expected_sentences.push_back(dir_rows[r].res);
        sentences_predicted++;
      end
    end
    drain();

    rand_chars = 0;

    // Random sentences with idling on both sides.
    while (rand_chars < 250) begin
      make_sentence(frame);
      send_frame(frame, 1'b1);
      rand_chars += frame.size();
    end

    // A stretch with neither side idling.
    src_steady = 1'b1;
    sink_mode <= SINK_STEADY;
    while (rand_chars < 450) begin
      make_sentence(frame);
      send_frame(frame, 1'b1);
      rand_chars += frame.size();
    end

    // Receiver holds off while sentences keep coming, so the input backs up.
    sink_mode <= SINK_HOLD;
    hold_base = sentences_predicted;
    for (int n = 0; n < 8 || sentences_predicted - hold_base < 3; n++) begin
      make_sentence(frame);
      send_frame(frame, 1'b1);
      rand_chars += frame.size();
    end
    sink_mode <= SINK_RANDOM;
    src_steady = 1'b0;
    drain();

    while (rand_chars < 800) begin
      make_sentence(frame);
      send_frame(frame, 1'b1);
      rand_chars += frame.size();
    end

    // Let the last sentence words arrive, then watch a little longer.
    rx_ch.valid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (expected_sentences.size() != 0 && wait_cycles < 5000);
    repeat (16) @(posedge clk);
    if (expected_sentences.size() != 0) begin
      log_error($sformatf("%0d expected sentences never arrived", expected_sentences.size()));
    end

    $display("Sent %0d characters (%0d inside sentences) through a %0d-row table and random",
             chars_sent, framed_chars, DIR_ROWS);
    $display("sentences; checked %0d sentence words, %0d with a verified checksum, %0d errors.",
             sentences_checked, sums_checked, error_count);
    if (error_count == 0) begin
      $display("nmea_sentence_framer_core verification clean");
    end else begin
      $display("nmea_sentence_framer_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/nsf_pkg.sv
sv/nsf_if.sv
sv/nmea_sentence_framer_core.sv
tb/nmea_sentence_framer_core_test.sv
